// ===== src/mzt_pkg.sv =====
// shared types and constants of the markup zone nesting tracker
// no dependencies; imported by the interfaces and every module of the block
package mzt_pkg;

  // field widths fixed by the event format
  localparam int KIND_W = 3;
  localparam int ID_W = 6;
  localparam int ID_COUNT = 2 ** ID_W;

  // event kinds as they arrive on the tag channel
  localparam logic [KIND_W-1:0] KIND_START   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_END     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NOINDEX = 3'd3;

  // operations handed from the front end to the back end
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
  localparam logic [OP_W-1:0] OP_START = 3'd1;
  localparam logic [OP_W-1:0] OP_EMPTY = 3'd2;
  localparam logic [OP_W-1:0] OP_END   = 3'd3;
  localparam logic [OP_W-1:0] OP_NOIDX = 3'd4;

  // queue between front and back, power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  // classified event
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            opens_zone;
    logic [ID_W-1:0] zone_ident;
    logic            noindex_is_close;
  } op_item_t;

  // one result beat
  typedef struct packed {
    logic            event_handled;
    logic            zone_opened;
    logic            zone_closed;
    logic [ID_W-1:0] result_zone;
    logic            is_noindex_zone;
    logic            already_open;
    logic            no_opening_tag;
    logic            stack_overflow;
  } mark_t;

endpackage

// ===== src/mzt_if.sv =====
// valid/ready channel interfaces for tag events in and zone marks out
// depends on mzt_pkg for field widths
interface mzt_tag_if import mzt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [KIND_W-1:0] event_kind;
  logic            opens_zone;
  logic [ID_W-1:0] zone_ident;
  logic            noindex_is_close;

  modport source (output valid, event_kind, opens_zone, zone_ident, noindex_is_close,
                  input ready);
  modport sink (input valid, event_kind, opens_zone, zone_ident, noindex_is_close,
                output ready);
endinterface

interface mzt_mark_if import mzt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            event_handled;
  logic            zone_opened;
  logic            zone_closed;
  logic [ID_W-1:0] result_zone;
  logic            is_noindex_zone;
  logic            already_open;
  logic            no_opening_tag;
  logic            stack_overflow;

  modport source (output valid, event_handled, zone_opened, zone_closed, result_zone,
                  is_noindex_zone, already_open, no_opening_tag, stack_overflow,
                  input ready);
  modport sink (input valid, event_handled, zone_opened, zone_closed, result_zone,
                is_noindex_zone, already_open, no_opening_tag, stack_overflow,
                output ready);
endinterface

// ===== src/mzt_front.sv =====
// front end: accepts tag event beats and classifies them into operations
// depends on mzt_pkg and mzt_tag_if
module mzt_front import mzt_pkg::*; (
  mzt_tag_if.sink  tags,
  input  logic     marking_enable,
  input  logic     q_ready,
  output logic     q_push,
  output op_item_t q_item
);

  // handshake straight onto the queue
  assign tags.ready = q_ready;
  assign q_push = tags.valid & q_ready;

  // classify the event kind
  always_comb begin
    q_item.opens_zone = tags.opens_zone;
    q_item.zone_ident = tags.zone_ident;
    q_item.noindex_is_close = tags.noindex_is_close;
    unique case (tags.event_kind)
      KIND_START:   q_item.op = OP_START;
      KIND_EMPTY:   q_item.op = OP_EMPTY;
      KIND_END:     q_item.op = OP_END;
      KIND_NOINDEX: q_item.op = marking_enable ? OP_NOIDX : OP_NONE;
      default:      q_item.op = OP_NONE;
    endcase
  end

endmodule

// ===== src/mzt_queue.sv =====
// short fifo of classified operations between front and back end
// depends on mzt_pkg
module mzt_queue import mzt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  op_item_t push_item,
  output logic     push_ready,
  input  logic     pop,
  output logic     pop_valid,
  output op_item_t pop_item
);

  op_item_t               slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]    wr_ptr;
  logic [QUEUE_AW-1:0]    rd_ptr;
  logic [QUEUE_AW:0]      count;

  assign push_ready = (count != (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QUEUE_AW + 1)'(1);
        2'b01:   count <= count - (QUEUE_AW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/mzt_back.sv =====
// back end: zone stack, open-zone bitmap, noindex flag and the result register
// depends on mzt_pkg and mzt_mark_if
module mzt_back import mzt_pkg::*; #(
  parameter int STACK_DEPTH = 32,
  parameter int ZONE_COUNT = 64,
  parameter int COUNT_WIDTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_valid,
  input  op_item_t q_item,
  output logic     q_pop,
  mzt_mark_if.source marks
);

  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int BIT_W = $clog2(ZONE_COUNT);

  typedef struct packed {
    logic [ID_W-1:0]        id;
    logic [COUNT_WIDTH-1:0] count;
  } frame_t;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);
  localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);

  // stack state: top frame in registers, frames below it in memory
  frame_t              stack_mem [STACK_DEPTH];
  frame_t              top, top_next;
  frame_t              below;
  logic [SP_W-1:0]     sp, sp_next;
  logic                mem_we;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       rd_addr;

  // zone bitmap and noindex flag
  logic [ZONE_COUNT-1:0] open_bits;
  logic                  bit_we;
  logic                  bit_val;
  logic [BIT_W-1:0]      bit_lut [ID_COUNT];
  logic [BIT_W-1:0]      bit_idx;
  logic                  cur_bit;
  logic                  inside_noindex, inside_noindex_next;

  // result register
  logic  res_valid;
  mark_t res, res_next;
  logic  take;

  // zone id to bitmap bit, folded at elaboration
  for (genvar z = 0; z < ID_COUNT; z++) begin : g_fold
    assign bit_lut[z] = BIT_W'(z % ZONE_COUNT);
  end

  assign take = q_valid & (~res_valid | marks.ready);
  assign q_pop = take;

  // one operation step
  always_comb begin
    logic [ID_W-1:0] zone;
    zone = q_item.zone_ident;
    res_next = '0;
    sp_next = sp;
    top_next = top;
    inside_noindex_next = inside_noindex;
    mem_we = 1'b0;
    bit_we = 1'b0;
    bit_val = 1'b0;
    if (q_item.op == OP_END) begin
      zone = top.id;
    end
    bit_idx = bit_lut[zone];
    cur_bit = open_bits[bit_idx];
    wr_addr = AW'(sp - SP_W'(1));

    if (take) begin
      unique case (q_item.op)
        OP_NOIDX: begin
          res_next.event_handled = 1'b1;
          if (q_item.noindex_is_close && inside_noindex) begin
            res_next.zone_closed = 1'b1;
            res_next.is_noindex_zone = 1'b1;
            inside_noindex_next = 1'b0;
          end else if (!inside_noindex) begin
            res_next.zone_opened = 1'b1;
            res_next.is_noindex_zone = 1'b1;
            inside_noindex_next = 1'b1;
          end
        end
        OP_END: begin
          res_next.event_handled = 1'b1;
          if (sp != '0) begin
            if (top.count <= COUNT_ONE) begin
              // last tag of the top zone closes and pops it
              res_next.zone_closed = 1'b1;
              res_next.result_zone = zone;
              res_next.no_opening_tag = ~cur_bit;
              bit_we = 1'b1;
              sp_next = sp - SP_W'(1);
              top_next = below;
            end else begin
              top_next.count = top.count - COUNT_ONE;
            end
          end
        end
        OP_EMPTY: begin
          res_next.event_handled = 1'b1;
          if (q_item.opens_zone) begin
            // opens and closes at once, bit ends clear
            res_next.zone_opened = 1'b1;
            res_next.zone_closed = 1'b1;
            res_next.result_zone = zone;
            res_next.already_open = cur_bit;
            bit_we = 1'b1;
          end
        end
        OP_START: begin
          res_next.event_handled = 1'b1;
          if (q_item.opens_zone && sp != SP_FULL) begin
            // push: current top goes to memory
            res_next.zone_opened = 1'b1;
            res_next.result_zone = zone;
            res_next.already_open = cur_bit;
            bit_we = 1'b1;
            bit_val = 1'b1;
            mem_we = (sp != '0);
            top_next.id = zone;
            top_next.count = COUNT_ONE;
            sp_next = sp + SP_W'(1);
          end else begin
            // plain start tag or dropped push deepens the top zone
            if (q_item.opens_zone) begin
              res_next.stack_overflow = 1'b1;
              res_next.result_zone = zone;
            end
            if (sp != '0 && top.count != COUNT_MAX) begin
              top_next.count = top.count + COUNT_ONE;
            end
          end
        end
        default: begin
          res_next = '0;
        end
      endcase
    end
    rd_addr = AW'(sp_next - SP_W'(2));
  end

  // stack memory with prefetch of the frame below the top
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[wr_addr] <= top;
    end
    if (mem_we && wr_addr == rd_addr) begin
      below <= top;
    end else begin
      below <= stack_mem[rd_addr];
    end
  end

  // top frame payload
  always_ff @(posedge clk) begin
    top <= top_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
      open_bits <= '0;
      inside_noindex <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      sp <= sp_next;
      inside_noindex <= inside_noindex_next;
      if (bit_we) begin
        open_bits[bit_idx] <= bit_val;
      end
      if (take) begin
        res_valid <= 1'b1;
      end else if (marks.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

  assign marks.valid = res_valid;
  assign marks.event_handled = res.event_handled;
  assign marks.zone_opened = res.zone_opened;
  assign marks.zone_closed = res.zone_closed;
  assign marks.result_zone = res.result_zone;
  assign marks.is_noindex_zone = res.is_noindex_zone;
  assign marks.already_open = res.already_open;
  assign marks.no_opening_tag = res.no_opening_tag;
  assign marks.stack_overflow = res.stack_overflow;

  // checks
  a_sp_range: assert property (@(posedge clk) disable iff (rst) sp <= SP_FULL)
    else $error("stack pointer beyond stack depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    take && q_item.op == OP_START && q_item.opens_zone && sp != SP_FULL
    |=> sp == $past(sp) + SP_W'(1))
    else $error("zone push did not grow the stack");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    take && q_item.op == OP_START && q_item.opens_zone && sp == SP_FULL
    |=> sp == SP_FULL)
    else $error("dropped push changed the stack pointer");

  a_noidx_only: assert property (@(posedge clk) disable iff (rst)
    !(take && q_item.op == OP_NOIDX) |=> $stable(inside_noindex))
    else $error("noindex flag moved without a noindex comment");

  a_one_bit: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> $countones(open_bits ^ $past(open_bits)) <= 1)
    else $error("more than one zone bit changed in a cycle");

endmodule

// ===== src/markup_zone_nesting_tracker_unit.sv =====
// top level of the markup zone nesting tracker: config register, front, queue, back
// depends on mzt_pkg, mzt_if, mzt_front, mzt_queue and mzt_back
//
// Takes one tag event beat per cycle unless the queue is full or the mark channel stalls
// (the top-of-stack registers are updated for every event), and returns exactly one mark
// beat per event, in order. An accepted beat is classified into a four-entry queue; the
// back end takes it once the result register is free or being read, and presents its
// mark from that register. The top frame lives in registers and the frame below it is
// prefetched from the stack memory through its one read port, so a pop does not wait
// for a memory read. The zone bitmap resets to all clear; the stack memory needs no
// clearing, since only frames below the stack pointer are read. The user must write
// noindex_marking_enable through cfg_wr_en and cfg_wr_data while idle; not enforced.
module markup_zone_nesting_tracker_unit import mzt_pkg::*; #(
  parameter int STACK_DEPTH = 32,
  parameter int ZONE_COUNT = 64,
  parameter int COUNT_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  mzt_tag_if.sink    tags,
  mzt_mark_if.source marks
);

  logic     noindex_marking_enable;
  logic     q_push;
  logic     q_ready;
  logic     q_pop;
  logic     q_valid;
  op_item_t q_in;
  op_item_t q_out;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      noindex_marking_enable <= 1'b0;
    end else if (cfg_wr_en) begin
      noindex_marking_enable <= cfg_wr_data;
    end
  end

  mzt_front u_front (
    .tags           (tags),
    .marking_enable (noindex_marking_enable),
    .q_ready        (q_ready),
    .q_push         (q_push),
    .q_item         (q_in)
  );

  mzt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_in),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_item   (q_out)
  );

  mzt_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .ZONE_COUNT  (ZONE_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_out),
    .q_pop   (q_pop),
    .marks   (marks)
  );

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for markup_zone_nesting_tracker_unit: tag beats in, zone marks out
// depends on mzt_pkg, the mzt_tag_if and mzt_mark_if interfaces and the rtl of the unit
// a zone tracker model in this file predicts every mark, which is checked in order
module tb_top;
  import mzt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_SLOTS = 32;
  localparam int ZONE_SLOTS = 64;
  localparam int DEPTH_W = 16;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
  localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd4;
  localparam int MAX_REPORTS = 20;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              opens;
    logic [ID_W-1:0]   ident;
    logic              nclose;
  } tag_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en;
  logic cfg_wr_data;

  mzt_tag_if  tag_bus ();
  mzt_mark_if mark_bus ();

  markup_zone_nesting_tracker_unit #(
    .STACK_DEPTH (STACK_SLOTS),
    .ZONE_COUNT  (ZONE_SLOTS),
    .COUNT_WIDTH (DEPTH_W)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .tags        (tag_bus),
    .marks       (mark_bus)
  );

  always #1 clk = ~clk;

  // tracker model state
  logic [ID_W-1:0]    zone_ids [STACK_SLOTS];
  logic [DEPTH_W-1:0] zone_depths [STACK_SLOTS];
  int                 zone_sp = 0;
  logic [ZONE_SLOTS-1:0] open_map = '0;
  logic               in_noindex = 1'b0;
  logic               noindex_en = 1'b0;

  tag_beat_t pending_tags [$];
  mark_t     expected_marks [$];

  int send_idle_pct;
  int recv_idle_pct;
  int error_count = 0;
  int beats_sent = 0;
  int marks_checked = 0;
  int opens_seen = 0;
  int closes_seen = 0;
  int dropped_pushes = 0;
  int saturated_deepens = 0;

  // one more tag inside the top zone, held at the count ceiling
  function automatic void deepen_top_zone();
    if (zone_sp > 0) begin
      if (zone_depths[zone_sp-1] == DEPTH_MAX) saturated_deepens++;
      else zone_depths[zone_sp-1] = zone_depths[zone_sp-1] + 1'b1;
    end
  endfunction

  // expected mark for one tag beat, advancing the model state
  function automatic mark_t track_zone_event(tag_beat_t t);
    mark_t           m;
    logic            opened;
    logic            closed;
    logic [ID_W-1:0] zone;
    int              bit_idx;
    m = '0;
    opened = 1'b0;
    closed = 1'b0;
    zone = '0;
    if (t.kind == KIND_NOINDEX) begin
      if (noindex_en) begin
        m.event_handled = 1'b1;
        if (t.nclose && in_noindex) begin
          m.zone_closed = 1'b1;
          m.is_noindex_zone = 1'b1;
          in_noindex = 1'b0;
        end else if (!in_noindex) begin
          m.zone_opened = 1'b1;
          m.is_noindex_zone = 1'b1;
          in_noindex = 1'b1;
        end
      end
    end else if (t.kind == KIND_START || t.kind == KIND_EMPTY || t.kind == KIND_END) begin
      m.event_handled = 1'b1;
      case (t.kind)
        KIND_END: begin
          if (zone_sp > 0) begin
            if (zone_depths[zone_sp-1] != '0)
              zone_depths[zone_sp-1] = zone_depths[zone_sp-1] - 1'b1;
            if (zone_depths[zone_sp-1] == '0) begin
              zone = zone_ids[zone_sp-1];
              closed = 1'b1;
              zone_sp--;
            end
          end
        end
        KIND_EMPTY: begin
          if (t.opens) begin
            zone = t.ident;
            opened = 1'b1;
            closed = 1'b1;
          end
        end
        default: begin
          if (t.opens) begin
            zone = t.ident;
            if (zone_sp < STACK_SLOTS) begin
              zone_ids[zone_sp] = t.ident;
              zone_depths[zone_sp] = DEPTH_W'(1);
              zone_sp++;
              opened = 1'b1;
            end else begin
              m.stack_overflow = 1'b1;
              deepen_top_zone();
            end
          end else begin
            deepen_top_zone();
          end
        end
      endcase
      bit_idx = int'(zone) % ZONE_SLOTS;
      if (opened) begin
        if (open_map[bit_idx]) m.already_open = 1'b1;
        else open_map[bit_idx] = 1'b1;
      end
      if (closed) begin
        if (open_map[bit_idx]) open_map[bit_idx] = 1'b0;
        else m.no_opening_tag = 1'b1;
      end
      m.zone_opened = opened;
      m.zone_closed = closed;
      m.result_zone = zone;
    end
    return m;
  endfunction

  // tag driver: retire the accepted beat, then hold, present the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      tag_bus.valid <= 1'b0;
    end else begin
      if (tag_bus.valid && tag_bus.ready) begin
        expected_marks.insert(expected_marks.size(),
                              track_zone_event(pending_tags.pop_front()));
        beats_sent++;
      end
      if (tag_bus.valid && !tag_bus.ready) begin
        // beat still waiting, keep it on the bus
      end else if (pending_tags.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        tag_bus.valid <= 1'b1;
        tag_bus.event_kind <= pending_tags[0].kind;
        tag_bus.opens_zone <= pending_tags[0].opens;
        tag_bus.zone_ident <= pending_tags[0].ident;
        tag_bus.noindex_is_close <= pending_tags[0].nclose;
      end else begin
        tag_bus.valid <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(string field, int unsigned want, int unsigned got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t ns: mark %0d %s mismatch, expected %0d, actual %0d",
               $time, marks_checked, field, want, got);
  endtask

  // mark monitor: compare each accepted beat with the oldest prediction
  always @(posedge clk) begin
    mark_t want;
    if (rst) begin
      mark_bus.ready <= 1'b0;
    end else begin
      if (mark_bus.valid && mark_bus.ready) begin
        if (expected_marks.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t ns: unexpected mark beat, expected none, actual zone %0d",
                     $time, mark_bus.result_zone);
        end else begin
          want = expected_marks.pop_front();
          if (mark_bus.event_handled !== want.event_handled)
            report_mismatch("event_handled", want.event_handled, mark_bus.event_handled);
          if (mark_bus.zone_opened !== want.zone_opened)
            report_mismatch("zone_opened", want.zone_opened, mark_bus.zone_opened);
          if (mark_bus.zone_closed !== want.zone_closed)
            report_mismatch("zone_closed", want.zone_closed, mark_bus.zone_closed);
          if (mark_bus.result_zone !== want.result_zone)
            report_mismatch("result_zone", want.result_zone, mark_bus.result_zone);
          if (mark_bus.is_noindex_zone !== want.is_noindex_zone)
            report_mismatch("is_noindex_zone", want.is_noindex_zone, mark_bus.is_noindex_zone);
          if (mark_bus.already_open !== want.already_open)
            report_mismatch("already_open", want.already_open, mark_bus.already_open);
          if (mark_bus.no_opening_tag !== want.no_opening_tag)
            report_mismatch("no_opening_tag", want.no_opening_tag, mark_bus.no_opening_tag);
          if (mark_bus.stack_overflow !== want.stack_overflow)
            report_mismatch("stack_overflow", want.stack_overflow, mark_bus.stack_overflow);
          marks_checked++;
          opens_seen += want.zone_opened;
          closes_seen += want.zone_closed;
          dropped_pushes += want.stack_overflow;
        end
      end
      mark_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_tag(logic [KIND_W-1:0] kind, logic opens, logic [ID_W-1:0] ident,
                          logic nclose);
    tag_beat_t t;
    t.kind = kind;
    t.opens = opens;
    t.ident = ident;
    t.nclose = nclose;
    pending_tags.insert(pending_tags.size(), t);
  endtask

  // sender has nothing left and every mark has come back, plus the pipeline latency
  task automatic wait_drained();
    while (pending_tags.size() != 0 || tag_bus.valid || expected_marks.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_noindex_enable(logic value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    noindex_en = value;
    @(negedge clk);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    @(posedge clk);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
    @(negedge clk);
  endtask

  // document-like tag stream: mostly balanced nesting, some empty tags and noindex
  // comments, and a share of noise with any kind and random fields
  task automatic random_doc_stream(int count);
    int nest;
    int roll;
    logic [ID_W-1:0] id;
    nest = 0;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      // reuse a few ids often so zones overlap
      id = ($urandom_range(1) == 0) ? ID_W'($urandom_range(7)) : ID_W'($urandom);
      if (roll < 10) begin
        push_tag(KIND_W'($urandom), 1'($urandom), ID_W'($urandom), 1'($urandom));
      end else if (roll < 45 && nest < 40) begin
        push_tag(KIND_START, $urandom_range(3) == 0, id, 1'($urandom));
        nest++;
      end else if (roll < 75 && nest > 0) begin
        push_tag(KIND_END, 1'($urandom), ID_W'($urandom), 1'($urandom));
        nest--;
      end else if (roll < 85) begin
        push_tag(KIND_EMPTY, 1'($urandom), id, 1'($urandom));
      end else if (roll < 93) begin
        push_tag(KIND_NOINDEX, 1'($urandom), ID_W'($urandom), 1'($urandom));
      end else begin
        push_tag(KIND_END, 1'($urandom), ID_W'($urandom), 1'($urandom));
      end
    end
  endtask

  // fill the stack past full, deepen the top zone a little, then unwind it all
  task automatic fill_past_full();
    for (int i = 0; i < STACK_SLOTS + 2; i++)
      push_tag(KIND_START, 1'b1, ID_W'($urandom), 1'($urandom));
    for (int i = 0; i < 4; i++)
      push_tag(KIND_START, 1'b0, ID_W'($urandom), 1'($urandom));
    for (int i = 0; i < STACK_SLOTS + 28; i++)
      push_tag(KIND_END, 1'($urandom), ID_W'($urandom), 1'($urandom));
  endtask

  // stimulus sequence
  initial begin
    tag_bus.valid = 1'b0;
    tag_bus.event_kind = '0;
    tag_bus.opens_zone = 1'b0;
    tag_bus.zone_ident = '0;
    tag_bus.noindex_is_close = 1'b0;
    mark_bus.ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    send_idle_pct = 34;
    recv_idle_pct = 46;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_noindex_enable(1'b1);

    // directed: empty stack, noindex markers, empty and nested zones, unhandled kinds
    push_tag(KIND_END, 1'b0, '0, 1'b0);
    push_tag(KIND_START, 1'b0, '0, 1'b0);
    push_tag(KIND_NOINDEX, 1'b0, '0, 1'b1);
    push_tag(KIND_NOINDEX, 1'b0, '0, 1'b0);
    push_tag(KIND_NOINDEX, 1'b0, '0, 1'b1);
    push_tag(KIND_EMPTY, 1'b1, '1, 1'b0);
    push_tag(KIND_START, 1'b1, '0, 1'b0);
    push_tag(KIND_EMPTY, 1'b1, '0, 1'b0);
    push_tag(KIND_START, 1'b0, '1, 1'b1);
    push_tag(KIND_END, 1'b0, '0, 1'b0);
    push_tag(KIND_END, 1'b0, '0, 1'b0);
    push_tag(KIND_START, 1'b1, ID_W'(21), 1'b0);
    push_tag(KIND_START, 1'b1, ID_W'(21), 1'b0);
    push_tag(KIND_END, 1'b1, '1, 1'b1);
    push_tag(KIND_END, 1'b0, '0, 1'b0);
    for (int k = KIND_IGNORED; k < 2 ** KIND_W; k++)
      push_tag(KIND_W'(k), 1'b1, '1, 1'b1);
    push_tag(KIND_EMPTY, 1'b0, ID_W'(42), 1'b0);
    push_tag(KIND_START, 1'b1, ID_W'(42), 1'b1);
    push_tag(KIND_END, 1'b1, '1, 1'b1);
    wait_drained();

    // random documents, with a full drain between the two halves
    random_doc_stream(70);
    wait_drained();
    random_doc_stream(70);
    wait_drained();

    // noindex comments ignored, idling swapped
    write_noindex_enable(1'b0);
    set_idling(46, 34);
    random_doc_stream(140);
    wait_drained();

    // noindex back on, no idling, then the full-stack run
    write_noindex_enable(1'b1);
    set_idling(0, 0);
    random_doc_stream(50);
    fill_past_full();
    random_doc_stream(50);
    wait_drained();
    repeat (8) @(negedge clk);

    if (expected_marks.size() != 0) begin
      error_count++;
      $display("%0t ns: %0d marks still expected, actual none", $time, expected_marks.size());
    end
    $display("sent %0d tag beats and checked %0d marks: %0d opens, %0d closes,",
             beats_sent, marks_checked, opens_seen, closes_seen);
    $display("%0d pushes dropped on a full stack, %0d deepens held at the count ceiling",
             dropped_pushes, saturated_deepens);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
src/mzt_pkg.sv
src/mzt_if.sv
src/mzt_front.sv
src/mzt_queue.sv
src/mzt_back.sv
src/markup_zone_nesting_tracker_unit.sv
tb/tb_top.sv
